// ----- sv/prpa_pkg.sv -----
// Package for the PageRank pull accumulator.
// Holds field widths, reset values, register indexes and the sequencer state type.
// No dependencies; every other file of the block depends on it.
package prpa_pkg;

  localparam int unsigned RANK_W   = 32;
  localparam int unsigned DEG_W    = 24;
  localparam int unsigned VTX_W    = 10;
  localparam int unsigned DAMP_W   = 16;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 32;
  localparam int unsigned DIV_CNT_W = 5;

  localparam logic [RANK_W-1:0] SAT32       = {RANK_W{1'b1}};
  localparam logic [DAMP_W-1:0] DAMPING_RST = 16'd55705;
  localparam logic [RANK_W-1:0] BASE_RST    = 32'd0;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DAMPING = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS    = 1'b1;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DIV  = 6'b000010,
    S_ACC  = 6'b000100,
    S_MUL  = 6'b001000,
    S_SUM  = 6'b010000,
    S_FIN  = 6'b100000
  } prpa_state_t;

endpackage

// ----- sv/prpa_in_if.sv -----
// Input channel of the PageRank pull accumulator: one in-edge item per transaction.
// Depends on prpa_pkg for the field widths.
interface prpa_in_if;
  logic                             valid;
  logic                             ready;
  logic [prpa_pkg::RANK_W-1:0]      source_rank;
  logic [prpa_pkg::DEG_W-1:0]       source_out_degree;
  logic [prpa_pkg::VTX_W-1:0]       vertex;
  logic                             no_edges;
  logic                             vertex_end;
  logic                             pass_first;
  logic                             pass_last;

  modport source (output valid, source_rank, source_out_degree, vertex, no_edges,
                  vertex_end, pass_first, pass_last, input ready);
  modport sink   (input valid, source_rank, source_out_degree, vertex, no_edges,
                  vertex_end, pass_first, pass_last, output ready);
endinterface

// ----- sv/prpa_out_if.sv -----
// Result channel of the PageRank pull accumulator: one updated vertex score per transaction.
// Depends on prpa_pkg for the field widths.
interface prpa_out_if;
  logic                        valid;
  logic                        ready;
  logic [prpa_pkg::VTX_W-1:0]  out_vertex;
  logic [prpa_pkg::RANK_W-1:0] new_score;
  logic                        saturated;

  modport source (output valid, out_vertex, new_score, saturated, input ready);
  modport sink   (input valid, out_vertex, new_score, saturated, output ready);
endinterface

// ----- sv/prpa_cfg_if.sv -----
// Configuration write channel of the PageRank pull accumulator.
// Depends on prpa_pkg for the index and data widths.
interface prpa_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [prpa_pkg::CFG_IDX_W-1:0] index;
  logic [prpa_pkg::CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/pagerank_pull_accumulator_top.sv -----
// Top level of the PageRank pull accumulator: divider, edge sum, damping and score store.
// Depends on prpa_pkg and the interfaces prpa_in_if, prpa_out_if and prpa_cfg_if.
//
//   channel  | direction | payload
//   ---------+-----------+------------------------------------------------------------
//   in_ch    | sink      | source_rank, source_out_degree, vertex, flags (4)
//   out_ch   | source    | out_vertex, new_score, saturated
//   cfg_ch   | sink      | index (0 damping, 1 bias), data
//
// An edge item with a nonzero out-degree is accepted, passes through 32 steps of the
// shared restoring divider (one quotient bit per cycle) and is then accumulated.
// An item that ends a vertex adds three steps: multiply, score read and add, final add and
// store write. An item without division does only these, and none if it ends no vertex.
// Reset (rst_n, synchronous) clears the sequencer, the edge sum and the output valid;
// the score store is not cleared and needs no clearing pass.
// A result waits in the output register; the block stalls in its final state only when
// that register is still full.
module pagerank_pull_accumulator_top #(
  parameter int unsigned MAX_VERTICES = 1024
) (
  input  logic       clk,
  input  logic       rst_n,
  prpa_in_if.sink    in_ch,
  prpa_out_if.source out_ch,
  prpa_cfg_if.sink   cfg_ch
);
  import prpa_pkg::*;

  localparam int unsigned ADDR_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

  prpa_state_t state_r, state_nxt;

  logic [DAMP_W-1:0]    damping_r;
  logic [RANK_W-1:0]    bias_r;

  logic [RANK_W-1:0]    quo_r, quo_nxt;
  logic [DEG_W-1:0]     rem_r, rem_nxt;
  logic [DEG_W-1:0]     deg_r, deg_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;

  logic [VTX_W-1:0]     vertex_r, vertex_nxt;
  logic                 in_range_r, in_range_nxt;
  logic                 end_r, end_nxt;
  logic                 first_r, first_nxt;
  logic                 last_r, last_nxt;

  logic [RANK_W-1:0]    edge_sum_r, edge_sum_nxt;
  logic                 sum_clip_r, sum_clip_nxt;
  logic [RANK_W-1:0]    scaled_r, scaled_nxt;
  logic [RANK_W-1:0]    score_r, score_nxt;
  logic                 clip_r, clip_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [VTX_W-1:0]     out_vertex_r, out_vertex_nxt;
  logic [RANK_W-1:0]    out_score_r, out_score_nxt;
  logic                 out_sat_r, out_sat_nxt;

  logic [RANK_W-1:0]    mem [MAX_VERTICES];
  logic [RANK_W-1:0]    mem_q_r;
  logic [ADDR_W-1:0]    mem_addr;
  logic                 mem_we;

  logic                 in_fire;
  logic                 fin_fire;
  logic                 do_div;
  logic                 ends_vertex;
  logic [31:0]          vtx_ext;
  logic [DEG_W:0]       trial;
  logic [DEG_W+1:0]     trial_diff;
  logic                 trial_ge;
  logic [RANK_W:0]      add_a;
  logic [RANK_W-1:0]    prior;
  logic [RANK_W+DAMP_W-1:0] product;

  assign in_ch.ready   = (state_r == S_IDLE);
  assign in_fire       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready  = 1'b1;
  assign fin_fire      = (state_r == S_FIN) && (!out_valid_r || out_ch.ready);

  assign do_div        = !in_ch.no_edges && (in_ch.source_out_degree != '0);
  assign ends_vertex   = in_ch.no_edges || in_ch.vertex_end;

  assign vtx_ext       = 32'(vertex_r);
  assign mem_addr      = vtx_ext[ADDR_W-1:0];
  assign mem_we        = fin_fire && in_range_r;

  // One restoring step: bring down the next dividend bit and try to subtract the divisor.
  assign trial         = {rem_r, quo_r[RANK_W-1]};
  assign trial_diff    = {1'b0, trial} - {2'b00, deg_r};
  assign trial_ge      = !trial_diff[DEG_W+1];

  assign product       = {{DAMP_W{1'b0}}, edge_sum_r} * {{RANK_W{1'b0}}, damping_r};
  assign prior         = in_range_r ? mem_q_r : '0;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_vertex = out_vertex_r;
  assign out_ch.new_score  = out_score_r;
  assign out_ch.saturated  = out_sat_r;

  always_comb begin
    state_nxt      = state_r;
    quo_nxt        = quo_r;
    rem_nxt        = rem_r;
    deg_nxt        = deg_r;
    cnt_nxt        = cnt_r;
    vertex_nxt     = vertex_r;
    in_range_nxt   = in_range_r;
    end_nxt        = end_r;
    first_nxt      = first_r;
    last_nxt       = last_r;
    edge_sum_nxt   = edge_sum_r;
    sum_clip_nxt   = sum_clip_r;
    scaled_nxt     = scaled_r;
    score_nxt      = score_r;
    clip_nxt       = clip_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_vertex_nxt = out_vertex_r;
    out_score_nxt  = out_score_r;
    out_sat_nxt    = out_sat_r;
    add_a          = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          quo_nxt      = in_ch.source_rank;
          rem_nxt      = '0;
          deg_nxt      = in_ch.source_out_degree;
          cnt_nxt      = '0;
          vertex_nxt   = in_ch.vertex;
          in_range_nxt = (32'(in_ch.vertex) < 32'(MAX_VERTICES));
          end_nxt      = ends_vertex;
          first_nxt    = in_ch.pass_first;
          last_nxt     = in_ch.pass_last;
          if (do_div) begin
            state_nxt = S_DIV;
          end else if (ends_vertex) begin
            state_nxt = S_MUL;
          end
        end
      end
      S_DIV: begin
        rem_nxt = trial_ge ? trial_diff[DEG_W-1:0] : trial[DEG_W-1:0];
        quo_nxt = {quo_r[RANK_W-2:0], trial_ge};
        cnt_nxt = cnt_r + DIV_CNT_W'(1);
        if (cnt_r == {DIV_CNT_W{1'b1}}) begin
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        add_a = {1'b0, edge_sum_r} + {1'b0, quo_r};
        if (add_a[RANK_W]) begin
          edge_sum_nxt = SAT32;
          sum_clip_nxt = 1'b1;
        end else begin
          edge_sum_nxt = add_a[RANK_W-1:0];
        end
        state_nxt = end_r ? S_MUL : S_IDLE;
      end
      S_MUL: begin
        // The store read of vertex_r is in flight during this cycle.
        scaled_nxt = product[RANK_W+DAMP_W-1:DAMP_W];
        state_nxt  = S_SUM;
      end
      S_SUM: begin
        if (first_r) begin
          score_nxt = scaled_r;
          clip_nxt  = 1'b0;
        end else begin
          add_a = {1'b0, prior} + {1'b0, scaled_r};
          score_nxt = add_a[RANK_W] ? SAT32 : add_a[RANK_W-1:0];
          clip_nxt  = add_a[RANK_W];
        end
        state_nxt = S_FIN;
      end
      S_FIN: begin
        add_a = {1'b0, score_r} + {1'b0, bias_r};
        if (last_r) begin
          out_score_nxt = add_a[RANK_W] ? SAT32 : add_a[RANK_W-1:0];
          out_sat_nxt   = sum_clip_r || clip_r || add_a[RANK_W];
        end else begin
          out_score_nxt = score_r;
          out_sat_nxt   = sum_clip_r || clip_r;
        end
        if (fin_fire) begin
          out_valid_nxt  = 1'b1;
          out_vertex_nxt = vertex_r;
          edge_sum_nxt   = '0;
          sum_clip_nxt   = 1'b0;
          state_nxt      = S_IDLE;
        end else begin
          out_score_nxt = out_score_r;
          out_sat_nxt   = out_sat_r;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      damping_r    <= DAMPING_RST;
      bias_r       <= BASE_RST;
      edge_sum_r   <= '0;
      sum_clip_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      edge_sum_r  <= edge_sum_nxt;
      sum_clip_r  <= sum_clip_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        unique case (cfg_ch.index)
          CFG_DAMPING: damping_r <= cfg_ch.data[DAMP_W-1:0];
          CFG_BIAS:    bias_r    <= cfg_ch.data[RANK_W-1:0];
          default:     ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r        <= quo_nxt;
    rem_r        <= rem_nxt;
    deg_r        <= deg_nxt;
    cnt_r        <= cnt_nxt;
    vertex_r     <= vertex_nxt;
    in_range_r   <= in_range_nxt;
    end_r        <= end_nxt;
    first_r      <= first_nxt;
    last_r       <= last_nxt;
    scaled_r     <= scaled_nxt;
    score_r      <= score_nxt;
    clip_r       <= clip_nxt;
    out_vertex_r <= out_vertex_nxt;
    out_score_r  <= out_score_nxt;
    out_sat_r    <= out_sat_nxt;
  end

  // Score store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= out_score_nxt;
    end
    mem_q_r <= mem[mem_addr];
  end

endmodule

// ----- sv/prpa_checker.sv -----
// Port-level checks for the PageRank pull accumulator, and the bind that attaches them.
// Depends on prpa_pkg for the field widths and on pagerank_pull_accumulator_top.
module prpa_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [prpa_pkg::DEG_W-1:0]  in_degree,
  input logic                        in_no_edges,
  input logic                        in_vertex_end,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [prpa_pkg::VTX_W-1:0]  out_vertex,
  input logic [prpa_pkg::RANK_W-1:0] out_score,
  input logic                        out_saturated
);
  import prpa_pkg::*;

  // A waiting result stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before it was taken");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_vertex) && $stable(out_score)
                                && $stable(out_saturated))
    else $error("stalled result changed");

  // An item that divides or ends a vertex keeps the block busy after its transaction.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_no_edges || in_vertex_end || in_degree != '0)
    |=> !in_ready)
    else $error("block took a new item while still working");

  // A new result appears only right after the busy final step.
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a finished vertex");

endmodule

bind pagerank_pull_accumulator_top prpa_checker u_prpa_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .in_degree     (in_ch.source_out_degree),
  .in_no_edges   (in_ch.no_edges),
  .in_vertex_end (in_ch.vertex_end),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_vertex    (out_ch.out_vertex),
  .out_score     (out_ch.new_score),
  .out_saturated (out_ch.saturated)
);
